### rtl/core/pcm_pkg.sv
`timescale 1ns / 1ps

package pcm_pkg;

  localparam int IN_CHANNELS  = 16;
  localparam int OUT_CHANNELS = 16;
  localparam int SAMPLE_WIDTH = 16;

  localparam int ACC_W   = 40;
  localparam int VAL_W   = 16;
  localparam int CH_W    = 4;
  localparam int FRAC_W  = 4;
  localparam int SAT_W   = (SAMPLE_WIDTH < 16) ? SAMPLE_WIDTH : 16;
  localparam int N_RES   = (OUT_CHANNELS < 16) ? OUT_CHANNELS : 16;
  localparam int IC_AW   = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
  localparam int CI_W    = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
  localparam int CNT_W   = (N_RES > 1) ? $clog2(N_RES) : 1;

  localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd8;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  // transaction traveling down the cell chain
  typedef struct packed {
    logic              valid;
    logic              is_wt;
    logic              clear;
    logic              emit;
    logic [CH_W-1:0]   oc;
    logic [IC_AW-1:0]  ic;
    logic [VAL_W-1:0]  value;
  } token_t;

  typedef struct packed {
    logic              load;
    logic              shift;
    logic [FRAC_W-1:0] frac;
  } ctrl_t;

  function automatic logic [VAL_W-1:0] sat_scale(logic signed [ACC_W-1:0] acc,
                                                 logic [FRAC_W-1:0] sh);
    logic signed [ACC_W-1:0] r;
    r = acc >>> sh;
    if (r > SAT_MAX) begin
      return VAL_W'(SAT_MAX);
    end else if (r < SAT_MIN) begin
      return VAL_W'(SAT_MIN);
    end
    return VAL_W'(r);
  endfunction

endpackage

### rtl/core/pcm_cell.sv
`timescale 1ns / 1ps

module pcm_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pcm_pkg::CI_W-1:0]   cell_idx_i,
  input  pcm_pkg::token_t            tok_i,
  output pcm_pkg::token_t            tok_o,
  input  pcm_pkg::ctrl_t             ctrl_i,
  input  logic [pcm_pkg::VAL_W-1:0]  slot_i,
  output logic [pcm_pkg::VAL_W-1:0]  slot_o,
  output logic                       emit_o
);
  import pcm_pkg::*;

  logic [VAL_W-1:0]        wmem [IN_CHANNELS];
  logic [VAL_W-1:0]        w_q;
  token_t                  tok_q;
  logic signed [2*VAL_W-1:0] prod_q;
  logic                    vb_q, clr_q, emit_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [VAL_W-1:0]        slot_q;
  logic                    wr_en;

  assign wr_en = tok_i.valid && tok_i.is_wt && (32'(tok_i.oc) == 32'(cell_idx_i));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wmem[tok_i.ic] <= tok_i.value;
    end
    w_q <= wmem[tok_i.ic];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(tok_q.value) * $signed(w_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      vb_q   <= 1'b0;
      clr_q  <= 1'b0;
      emit_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      tok_q  <= tok_i;
      vb_q   <= tok_q.valid && !tok_q.is_wt;
      clr_q  <= tok_q.clear;
      emit_q <= tok_q.emit;
      if (vb_q) begin
        acc_q <= clr_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      slot_q <= sat_scale(acc_q, ctrl_i.frac);
    end else if (ctrl_i.shift) begin
      slot_q <= slot_i;
    end
  end

  assign tok_o  = tok_q;
  assign slot_o = slot_q;
  assign emit_o = vb_q && emit_q;

endmodule

### rtl/core/pointwise_conv_mac_top.sv
`timescale 1ns / 1ps
// Weight loads and samples are accepted one transaction per cycle while tready is high.
// After the sample of the last input channel the input stalls; the first result shows
// once that sample has walked down the cell chain and the slots are loaded. Results
// then leave one per cycle through cell 0 while m_axis_tready is high; input resumes
// after the last. Reset clears accumulators and control and sets frac_bits to 8;
// weights are undefined until loaded.

module pointwise_conv_mac_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,   // frac_bits
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // out_channel[3:0], in_channel[7:4], value[23:8]
  input  logic [0:0]  s_axis_tuser,  // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // result_channel[3:0], result_value[19:4], zero[23:20]
  output logic        m_axis_tlast   // last_of_pixel
);
  import pcm_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_WAIT,
    ST_LOAD,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              mvalid_q;
  logic [FRAC_W-1:0] frac_q;

  logic              s_hs, m_hs, is_wt, ic_ok, is_last;
  logic [CH_W-1:0]   in_oc, in_ic;
  logic [VAL_W-1:0]  in_val, sample;
  logic signed [SAT_W-1:0] sample_n;
  token_t            tok [OUT_CHANNELS+1];
  logic [VAL_W-1:0]  slot [OUT_CHANNELS+1];
  logic              emit [OUT_CHANNELS];
  ctrl_t             ctrl;

  assign in_oc    = s_axis_tdata[3:0];
  assign in_ic    = s_axis_tdata[7:4];
  assign in_val   = s_axis_tdata[23:8];
  assign is_wt    = !s_axis_tuser[0];
  assign sample_n = in_val[SAT_W-1:0];
  assign sample   = VAL_W'(sample_n);
  assign ic_ok    = 32'(in_ic) < IN_CHANNELS;
  assign is_last  = 32'(in_ic) == IN_CHANNELS - 1;

  assign s_axis_tready = (state_q == ST_RUN);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign m_hs          = mvalid_q && m_axis_tready;

  always_comb begin
    tok[0].valid = s_hs && ic_ok;
    tok[0].is_wt = is_wt;
    tok[0].clear = !is_wt && (in_ic == '0);
    tok[0].emit  = !is_wt && is_last;
    tok[0].oc    = in_oc;
    tok[0].ic    = IC_AW'(in_ic);
    tok[0].value = is_wt ? in_val : sample;
  end

  assign ctrl.load  = (state_q == ST_LOAD);
  assign ctrl.shift = m_hs;
  assign ctrl.frac  = frac_q;
  assign slot[OUT_CHANNELS] = '0;

  for (genvar i = 0; i < OUT_CHANNELS; i++) begin : g_cell
    pcm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CI_W'(i)),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1]),
      .ctrl_i     (ctrl),
      .slot_i     (slot[i+1]),
      .slot_o     (slot[i]),
      .emit_o     (emit[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= FRAC_RESET;
    end else if (cfg_we_i) begin
      frac_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      cnt_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_RUN: begin
          if (s_hs && tok[0].valid && tok[0].emit) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (emit[OUT_CHANNELS-1]) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_q  <= ST_DRAIN;
          cnt_q    <= '0;
          mvalid_q <= 1'b1;
        end
        ST_DRAIN: begin
          if (m_hs) begin
            if (cnt_q == CNT_W'(N_RES - 1)) begin
              mvalid_q <= 1'b0;
              state_q  <= ST_RUN;
            end else begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
        end
        default: state_q <= ST_RUN;
      endcase
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tlast  = (cnt_q == CNT_W'(N_RES - 1));
  assign m_axis_tdata  = {4'd0, slot[0], CH_W'(cnt_q)};

endmodule

### rtl/core/pcm_checker.sv
`timescale 1ns / 1ps

module pcm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_input_during_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while results pending");

  a_first_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> m_axis_tdata[3:0] == 4'd0)
    else $error("pixel does not start at channel 0");

  a_channel_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[3:0] == 4'($past(m_axis_tdata[3:0]) + 4'd1))
    else $error("result channel out of sequence");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result after last of pixel");

endmodule

bind pointwise_conv_mac_top pcm_checker u_pcm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
